>>> rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAP_WORD_W = 32;                 // map bits per memory word
  localparam int BIT_SEL_W  = $clog2(MAP_WORD_W); // bit select within a word

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 8'd0,
    REG_PAGE_COUNT   = 8'd1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

>>> rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a one-bit-per-page map held in a word RAM.
// ----------------------------------------------------------------------------
// Allocate: each map word scanned takes a RAM read, then a check/update, and
//   S_FINISH loads the result; ceil(MAX_PAGES/32) words at most (8 at 256 pages).
// Free: RAM read, clear-bit write, finish, idle; out of range, straight to finish.
// One request at a time; the next is taken once the result is registered,
//   which waits while a stalled result still holds the output.
// Reset: synchronous; a clearing pass over all ceil(MAX_PAGES/32) map words
//   zeroes the map while in_stall is high. Configuration writes are taken at any time.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [31:0]           address,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           page_address,
  output logic [7:0]            page_index,
  output logic [1:0]            status
);

  localparam int WORDS = (MAX_PAGES + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int GI_W  = WA_W + BIT_SEL_W;            // global page index
  localparam int NW    = (GI_W + 1 > 9) ? GI_W + 1 : 9;
  localparam int PI_W  = 32 - PAGE_SHIFT;             // index from an address

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ALLOC_RD, S_ALLOC_CHK, S_FREE_RD, S_FREE_WR, S_FINISH
  } state_t;

  state_t state;

  logic [31:0]     base_address;
  logic [8:0]      page_count;
  logic [WA_W-1:0] word;
  logic [GI_W-1:0] res_index;
  logic [1:0]      res_status;
  logic            res_alloc;

  logic                  ram_we;
  logic [MAP_WORD_W-1:0] ram_wdata;
  logic [MAP_WORD_W-1:0] ram_rdata;

  logic [NW-1:0]         cnt_ext;
  logic [NW-1:0]         active;
  logic                  in_take;
  logic                  out_free;
  logic [31:0]           offset;
  logic [PI_W-1:0]       free_idx;
  logic                  free_ok;
  logic [MAP_WORD_W-1:0] free_vec;
  logic                  any_free;
  logic [BIT_SEL_W-1:0]  free_pos;
  logic [GI_W:0]         next_start;
  logic                  last_word;
  logic [GI_W-1:0]       glob;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign cnt_ext = NW'(page_count);
  assign active  = (cnt_ext > NW'(MAX_PAGES)) ? NW'(MAX_PAGES) : cnt_ext;

  // free: page index from the offset into the region
  assign offset   = address - base_address;
  assign free_idx = offset[31:PAGE_SHIFT];
  assign free_ok  = (32'(free_idx) < 32'(active));

  // pages past the active count look allocated to the search
  always_comb begin
    free_vec = '0;
    for (int b = 0; b < MAP_WORD_W; b++) begin
      free_vec[b] = !ram_rdata[b] && (NW'({word, BIT_SEL_W'(b)}) < active);
    end
  end

  always_comb begin
    free_pos = '0;
    for (int b = MAP_WORD_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        free_pos = BIT_SEL_W'(b);
      end
    end
  end

  assign any_free   = |free_vec;
  assign next_start = {1'b0, word, {BIT_SEL_W{1'b0}}} + (GI_W+1)'(MAP_WORD_W);
  assign last_word  = (word == WA_W'(WORDS - 1)) ||
                      (NW'(next_start) >= active);
  assign glob       = res_index;

  // RAM write side
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_ALLOC_CHK: begin
        ram_we    = any_free;
        ram_wdata = ram_rdata | (MAP_WORD_W'(1) << free_pos);
      end
      S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(MAP_WORD_W'(1) << glob[BIT_SEL_W-1:0]);
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
      end
    endcase
  end

  bpa_ram #(
    .WIDTH (MAP_WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word),
    .wdata (ram_wdata),
    .raddr (word),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      page_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_PAGE_COUNT:   page_count   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      word      <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_FINISH loads the output register itself
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (word == WA_W'(WORDS - 1)) begin
            word  <= '0;
            state <= S_IDLE;
          end else begin
            word <= word + WA_W'(1);
          end
        end
        S_IDLE: begin
          if (in_take) begin
            if (func == FUNC_ALLOC) begin
              word      <= '0;
              res_alloc <= 1'b1;
              state     <= S_ALLOC_RD;
            end else begin
              res_alloc <= 1'b0;
              if (free_ok) begin
                res_index  <= GI_W'(free_idx);
                res_status <= ST_OK;
                word       <= free_idx[GI_W-1:BIT_SEL_W];
                state      <= S_FREE_RD;
              end else begin
                res_index  <= '0;
                res_status <= ST_RANGE;
                state      <= S_FINISH;
              end
            end
          end
        end
        S_ALLOC_RD: begin
          state <= S_ALLOC_CHK;
        end
        S_ALLOC_CHK: begin
          if (any_free) begin
            res_index  <= {word, free_pos};
            res_status <= ST_OK;
            state      <= S_FINISH;
          end else if (last_word) begin
            res_index  <= '0;
            res_status <= ST_FULL;
            state      <= S_FINISH;
          end else begin
            word  <= word + WA_W'(1);
            state <= S_ALLOC_RD;
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_WR;
        end
        S_FREE_WR: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            page_index <= 8'(res_index);
            status     <= res_status;
            if (res_alloc && res_status == ST_OK) begin
              page_address <= base_address + (32'(res_index) << PAGE_SHIFT);
            end else begin
              page_address <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap page allocator. Directed requests cover
// the region corners first, then randomized alloc/free traffic runs over a
// series of region settings. Every result is checked against a bench-side
// copy of the page map. Both sides idle at random, and one long result stall
// backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;

  localparam int MAP_PAGES     = 256;
  localparam int PAGE_BITS     = 12;
  localparam int PAGE_BYTES    = 1 << PAGE_BITS;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 24;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

  typedef struct packed {
    logic [31:0] page_address;
    logic [7:0]  page_index;
    status_t     status;
  } page_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  func;
  logic [31:0]           address;
  logic                  out_valid;
  logic                  out_stall;
  logic [31:0]           page_address;
  logic [7:0]            page_index;
  logic [1:0]            status;

  // bench copy of the allocator state
  logic [31:0]          model_base;
  logic [8:0]           model_pages;
  logic [MAP_PAGES-1:0] model_map;
  page_result_t         pending_results[$];

  bit src_quiet    = 1'b0;
  bit sink_quiet   = 1'b0;
  bit hold_pending = 1'b0;

  int mismatches      = 0;
  int results_checked = 0;
  int requests_sent   = 0;
  int full_seen       = 0;
  int range_seen      = 0;
  int reg_writes      = 0;
  int idle_cycles     = 0;

  bitmap_page_allocator #(
    .MAX_PAGES (MAP_PAGES),
    .PAGE_SHIFT(PAGE_BITS)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .address     (address),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .page_address(page_address),
    .page_index  (page_index),
    .status      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_pages();
    return (model_pages > MAP_PAGES) ? MAP_PAGES : model_pages;
  endfunction

  // First-fit search for allocate, index conversion and bit clear for free.
  function automatic page_result_t apply_request(func_t kind, logic [31:0] addr);
    page_result_t r;
    int unsigned  n;
    int unsigned  i;
    logic [31:0]  offset;
    logic [31:0]  idx;
    r.page_address = '0;
    r.page_index   = '0;
    r.status       = ST_OK;
    n = active_pages();
    if (kind == FUNC_ALLOC) begin
      r.status = ST_FULL;
      for (i = 0; i < n; i++) begin
        if (!model_map[i]) begin
          model_map[i]   = 1'b1;
          r.page_address = model_base + (32'(i) << PAGE_BITS);
          r.page_index   = i[7:0];
          r.status       = ST_OK;
          break;
        end
      end
    end else begin
      offset = addr - model_base;
      idx    = offset >> PAGE_BITS;
      if (idx < n) begin
        model_map[idx[7:0]] = 1'b0;
        r.page_index        = idx[7:0];
      end else begin
        r.status = ST_RANGE;
      end
    end
    return r;
  endfunction

  task automatic send_request(func_t kind, logic [31:0] addr);
    page_result_t r;
    int           gap;
    gap = src_quiet ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= kind;
    address  <= addr;
    do @(posedge clk); while (in_stall);
    r = apply_request(kind, addr);
    pending_results.push_back(r);
    requests_sent++;
    if (r.status == ST_FULL) full_seen++;
    if (r.status == ST_RANGE) range_seen++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BASE_ADDRESS: model_base  = data;
      REG_PAGE_COUNT:   model_pages = data[8:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only once the last request has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_region(logic [31:0] base, logic [31:0] count);
    wait_idle();
    write_reg(REG_BASE_ADDRESS, base);
    write_reg(REG_PAGE_COUNT, count);
  endtask

  task automatic run_traffic(logic [31:0] base, logic [31:0] count, int alloc_pct,
                             int items);
    int          k;
    int          pick;
    int          n;
    logic [31:0] addr;
    set_region(base, count);
    for (k = 0; k < items; k++) begin
      n    = active_pages();
      addr = $urandom();
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_request(FUNC_ALLOC, addr);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70 && n > 0)
          addr = model_base + ($urandom_range(0, n - 1) << PAGE_BITS)
                 + $urandom_range(0, PAGE_BYTES - 1);
        else if (pick < 85)
          addr = model_base + (32'(n) << PAGE_BITS) + $urandom_range(0, 2 * PAGE_BYTES);
        else if (pick < 90)
          addr = model_base - $urandom_range(1, PAGE_BYTES);
        send_request(FUNC_FREE, addr);
      end
    end
  endtask

  task automatic test_empty_region();
    // page count is zero out of reset
    send_request(FUNC_ALLOC, 32'h0);
    send_request(FUNC_FREE, 32'h0);
    send_request(FUNC_FREE, 32'hFFFF_FFFF);
  endtask

  task automatic test_wrap_and_bounds();
    logic [31:0] base;
    int          k;
    base = 32'hFFFF_E000;
    set_region(base, 4);
    // pages 2 and 3 sit past the 32-bit wrap
    for (k = 0; k < 4; k++) send_request(FUNC_ALLOC, $urandom());
    send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
    send_request(FUNC_FREE, base + 2 * PAGE_BYTES + 32'hABC);
    send_request(FUNC_ALLOC, 32'h0);
    send_request(FUNC_FREE, base + 4 * PAGE_BYTES - 1);
    send_request(FUNC_FREE, base + 3 * PAGE_BYTES);   // already free
    send_request(FUNC_FREE, base - 1);
    send_request(FUNC_FREE, base + 4 * PAGE_BYTES);   // first page past the bound
  endtask

  task automatic test_shrink_and_oversize();
    set_region(model_base, 2);
    send_request(FUNC_FREE, model_base + 2 * PAGE_BYTES);
    send_request(FUNC_ALLOC, 32'h0);
    wait_idle();
    write_reg(REG_PAGE_COUNT, 32'hFFFF_FFFF);           // 511 after masking
    send_request(FUNC_ALLOC, 32'h0);
    wait_idle();
    write_reg(REG_SPARE, 32'h0);
    write_reg(REG_TOP, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 32'h0);
    wait_idle();
    write_reg(REG_PAGE_COUNT, 3);
    send_request(FUNC_FREE, model_base + 2 * PAGE_BYTES);
    send_request(FUNC_ALLOC, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    run_traffic(32'h0, MAP_PAGES, 75, 400);
    run_traffic(32'hFFFF_FFFF, 511, 30, 300);
  endtask

  task automatic test_small_regions();
    run_traffic($urandom(), 1, 50, 150);
    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    run_traffic($urandom(), 33, 55, 250);
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    run_traffic($urandom(), 32, 60, 200);
  endtask

  task automatic test_random_regions();
    int k;
    for (k = 0; k < 2; k++)
      run_traffic($urandom(), $urandom_range(0, 511), $urandom_range(30, 70), 170);
  endtask

  task automatic test_backpressure();
    int k;
    set_region($urandom(), 16);
    src_quiet    = 1'b1;
    hold_pending = 1'b1;
    for (k = 0; k < 25; k++) begin
      if (k % 3 == 0)
        send_request(FUNC_FREE, model_base + ($urandom_range(0, 15) << PAGE_BITS));
      else
        send_request(FUNC_ALLOC, $urandom());
    end
    src_quiet = 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    out_stall = 1'b0;
    forever begin
      gap = sink_quiet ? 0 : $urandom_range(0, 9);
      if (hold_pending) begin
        hold_pending = 1'b0;
        gap          = HOLD_CYCLES;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    page_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: addr %h index %0d status %0d",
                   $time, page_address, page_index, status);
      end else begin
        want = pending_results.pop_front();
        if (page_address !== want.page_address || page_index !== want.page_index ||
            status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch addr %h/%h index %0d/%0d status %0d/%0d (exp/act)",
                     $time, want.page_address, page_address, want.page_index,
                     page_index, want.status, status);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    int k;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    func        = FUNC_ALLOC;
    address     = '0;
    model_base  = '0;
    model_pages = '0;
    model_map   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_empty_region();
    test_wrap_and_bounds();
    test_shrink_and_oversize();
    test_fill_and_drain();
    test_small_regions();
    test_backpressure();
    test_random_regions();

    @(negedge clk);
    in_valid <= 1'b0;
    for (k = 0; k < IDLE_LIMIT && pending_results.size() != 0; k++) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d requests, %0d results checked, %0d mismatches",
             requests_sent, results_checked, mismatches);
    $display("summary: %0d region-full, %0d out-of-range, %0d register writes",
             full_seen, range_seen, reg_writes);
    if (mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
